// ----- src/h264kg_pkg.sv -----
package h264kg_pkg;

  // Field widths.
  localparam int unsigned DataW   = 8;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned DurW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FillW   = 3;
  localparam int unsigned NalW    = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_VIDEO_DUR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_AUDIO_DUR = 2'd1;

  // Durations after reset.
  localparam logic [DurW-1:0] VIDEO_DUR_RESET = 32'd66667;
  localparam logic [DurW-1:0] AUDIO_DUR_RESET = 32'd960;

  // Start code bytes.
  localparam logic [DataW-1:0] SC_ZERO = 8'h00;
  localparam logic [DataW-1:0] SC_ONE  = 8'h01;

  // NAL unit types of interest.
  localparam logic [NalW-1:0] NAL_SPS = 5'd7;
  localparam logic [NalW-1:0] NAL_PPS = 5'd8;
  localparam logic [NalW-1:0] NAL_IDR = 5'd5;

  // Window depth and candidates to skip after a three- or four-byte start code.
  localparam logic [FillW-1:0] WIN_FULL   = 3'd4;
  localparam logic [FillW-1:0] SKIP_SHORT = 3'd3;
  localparam logic [FillW-1:0] SKIP_LONG  = 3'd4;

  typedef logic [DataW-1:0] byte_t;

  typedef struct packed {
    logic             accepted;
    logic             key_frame;
    logic             stream_id;
    logic [TimeW-1:0] timestamp;
    logic [DurW-1:0]  duration;
  } res_t;

endpackage

// ----- src/h264kg_pkt_if.sv -----
interface h264kg_pkt_if
  import h264kg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;
  logic             is_video;

  modport source (output valid, output data_byte, output last_byte, output is_video,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input is_video,
                output ready);
endinterface

// ----- src/h264kg_res_if.sv -----
interface h264kg_res_if
  import h264kg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             key_frame;
  logic             stream_id;
  logic [TimeW-1:0] timestamp;
  logic [DurW-1:0]  duration;

  modport source (output valid, output accepted, output key_frame, output stream_id,
                  output timestamp, output duration, input ready);
  modport sink (input valid, input accepted, input key_frame, input stream_id,
                input timestamp, input duration, output ready);
endinterface

// ----- src/h264kg_cfg_if.sv -----
interface h264kg_cfg_if
  import h264kg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DurW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/h264_keyframe_gate_timestamper_top.sv -----
// H.264 keyframe gate and timestamper. Packet bytes arrive on pkt at one byte per
// clock while pkt ready is high; video bytes are scanned for Annex B start codes
// in a four-byte window, and the packet counts as a keyframe once SPS, PPS and then
// IDR have been seen. Video is dropped (accepted low, all other fields zero) until
// the first keyframe. On each final byte one result is transferred on res, carrying
// the per-kind 64-bit timestamp and duration. The whole scan step and the 64-bit
// timestamp add sit between the byte being taken and the result register. The
// result register is backed by a skid register, so pkt ready falls only when two
// results are waiting on res. Duration registers are written on cfg (index 0
// video, index 1 audio) and are always ready.
module h264_keyframe_gate_timestamper_top
  import h264kg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  h264kg_pkt_if.sink        pkt,
  h264kg_res_if.source      res,
  h264kg_cfg_if.sink        cfg
);

  // Configuration and timestamp state.
  logic [DurW-1:0]  video_dur;
  logic [DurW-1:0]  audio_dur;
  logic [TimeW-1:0] video_time, video_time_next;
  logic [TimeW-1:0] audio_time, audio_time_next;
  logic             first_key, first_key_next;

  // Per-packet scan state.
  byte_t            win [4];
  byte_t            win_next [4];
  logic [FillW-1:0] fill, fill_next;
  logic [FillW-1:0] skip, skip_next;
  logic             seen_sps, seen_sps_next;
  logic             seen_pps, seen_pps_next;
  logic             seen_idr, seen_idr_next;

  // Result register and skid register.
  logic out_valid;
  res_t out_res;
  logic skid_valid;
  res_t skid_res;

  logic            acc;
  logic            produce;
  logic            take;
  res_t            new_res;
  logic [NalW-1:0] nal_type;
  logic            nal_hit;
  logic            key;
  logic            pass;

  assign pkt.ready = !skid_valid;
  assign acc       = pkt.valid && pkt.ready;
  assign produce   = acc && pkt.last_byte;
  assign take      = res.valid && res.ready;
  assign cfg.ready = 1'b1;

  // Scan step, result build and end-of-packet clear.
  always_comb begin
    win_next        = win;
    fill_next       = fill;
    skip_next       = skip;
    seen_sps_next   = seen_sps;
    seen_pps_next   = seen_pps;
    seen_idr_next   = seen_idr;
    first_key_next  = first_key;
    video_time_next = video_time;
    audio_time_next = audio_time;
    nal_type        = '0;
    nal_hit         = 1'b0;
    key             = 1'b0;
    pass            = 1'b0;
    new_res         = '0;

    if (acc && pkt.is_video) begin
      // Test the candidate at the oldest window byte once four bytes follow it.
      if (fill == WIN_FULL && !seen_idr) begin
        if (skip != '0) begin
          skip_next = skip - 3'd1;
        end else if (win[0] == SC_ZERO && win[1] == SC_ZERO) begin
          if (win[2] == SC_ONE) begin
            nal_type  = win[3][NalW-1:0];
            nal_hit   = 1'b1;
            skip_next = SKIP_SHORT;
          end else if (win[2] == SC_ZERO && win[3] == SC_ONE) begin
            nal_type  = pkt.data_byte[NalW-1:0];
            nal_hit   = 1'b1;
            skip_next = SKIP_LONG;
          end
        end
      end
      if (nal_hit) begin
        case (nal_type)
          NAL_SPS: seen_sps_next = 1'b1;
          NAL_PPS: seen_pps_next = 1'b1;
          NAL_IDR: seen_idr_next = 1'b1;
          default: ;
        endcase
      end
      win_next[0] = win[1];
      win_next[1] = win[2];
      win_next[2] = win[3];
      win_next[3] = pkt.data_byte;
      if (fill < WIN_FULL) begin
        fill_next = fill + 3'd1;
      end
    end

    if (produce) begin
      if (pkt.is_video) begin
        key  = seen_sps_next && seen_pps_next && seen_idr_next;
        pass = key || first_key;
        first_key_next = first_key || key;
        if (pass) begin
          new_res.accepted  = 1'b1;
          new_res.key_frame = key;
          new_res.timestamp = video_time;
          new_res.duration  = video_dur;
          video_time_next   = video_time + {{(TimeW-DurW){1'b0}}, video_dur};
        end
      end else begin
        new_res.accepted  = 1'b1;
        new_res.stream_id = 1'b1;
        new_res.timestamp = audio_time;
        new_res.duration  = audio_dur;
        audio_time_next   = audio_time + {{(TimeW-DurW){1'b0}}, audio_dur};
      end
      // Every packet starts with an empty scan state.
      for (int i = 0; i < 4; i++) begin
        win_next[i] = '0;
      end
      fill_next     = '0;
      skip_next     = '0;
      seen_sps_next = 1'b0;
      seen_pps_next = 1'b0;
      seen_idr_next = 1'b0;
    end
  end

  // Scan, timestamp and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      video_dur  <= VIDEO_DUR_RESET;
      audio_dur  <= AUDIO_DUR_RESET;
      video_time <= '0;
      audio_time <= '0;
      first_key  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        win[i] <= '0;
      end
      fill     <= '0;
      skip     <= '0;
      seen_sps <= 1'b0;
      seen_pps <= 1'b0;
      seen_idr <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_VIDEO_DUR: video_dur <= cfg.data;
          CFG_AUDIO_DUR: audio_dur <= cfg.data;
          default: ;
        endcase
      end
      video_time <= video_time_next;
      audio_time <= audio_time_next;
      first_key  <= first_key_next;
      win        <= win_next;
      fill       <= fill_next;
      skip       <= skip_next;
      seen_sps   <= seen_sps_next;
      seen_pps   <= seen_pps_next;
      seen_idr   <= seen_idr_next;
    end
  end

  // Result register with skid: a new result lands in the skid only while the
  // result register is held by a stalled transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= produce;
        end
      end else if (produce) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (produce) begin
        out_res <= new_res;
      end
    end else if (produce) begin
      skid_res <= new_res;
    end
  end

  assign res.valid     = out_valid;
  assign res.accepted  = out_res.accepted;
  assign res.key_frame = out_res.key_frame;
  assign res.stream_id = out_res.stream_id;
  assign res.timestamp = out_res.timestamp;
  assign res.duration  = out_res.duration;

endmodule

// ----- src/h264kg_chk.sv -----
module h264kg_chk
  import h264kg_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic             accepted,
  input logic             key_frame,
  input logic             stream_id,
  input logic [TimeW-1:0] timestamp,
  input logic [DurW-1:0]  duration
);

  // A stalled result keeps its timestamp.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(timestamp))
    else $error("result changed while stalled");

  // A dropped video packet carries nothing but zeros.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && !accepted |-> !key_frame && !stream_id && timestamp == '0
                               && duration == '0)
    else $error("dropped packet with non-zero fields");

  // Audio results are always passed and never keyframes.
  a_audio: assert property (@(posedge clk) disable iff (rst)
    res_valid && stream_id |-> accepted && !key_frame)
    else $error("audio result not passed or marked key");

  // A keyframe is a passed video packet.
  a_key: assert property (@(posedge clk) disable iff (rst)
    res_valid && key_frame |-> accepted && !stream_id)
    else $error("keyframe on wrong stream or dropped");

endmodule

bind h264_keyframe_gate_timestamper_top h264kg_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .accepted  (res.accepted),
  .key_frame (res.key_frame),
  .stream_id (res.stream_id),
  .timestamp (res.timestamp),
  .duration  (res.duration)
);

// ----- tb/h264kg_checker.sv -----
module h264kg_checker
  import h264kg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  h264kg_pkt_if       pkt,
  h264kg_res_if       res,
  h264kg_cfg_if       cfg,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the durations and of the scanner state.
  logic [DurW-1:0]  video_dur;
  logic [DurW-1:0]  audio_dur;
  byte_t            win [4];
  logic [FillW-1:0] fill;
  logic [FillW-1:0] skip_left;
  logic             got_sps;
  logic             got_pps;
  logic             got_idr;
  logic             first_key;
  logic [TimeW-1:0] video_time;
  logic [TimeW-1:0] audio_time;

  // Packet results still owed by the block, oldest first.
  res_t             packet_results_q [$];

  // Every packet starts with an empty window and no NAL units noted.
  function automatic void start_new_packet();
    foreach (win[i]) win[i] = SC_ZERO;
    fill      = '0;
    skip_left = '0;
    got_sps   = 1'b0;
    got_pps   = 1'b0;
    got_idr   = 1'b0;
  endfunction

  // Note the NAL unit type carried by a header byte.
  function automatic void note_nal(input byte_t hdr);
    case (hdr[NalW-1:0])
      NAL_SPS: got_sps = 1'b1;
      NAL_PPS: got_pps = 1'b1;
      NAL_IDR: got_idr = 1'b1;
      default: ;
    endcase
  endfunction

  // Advance the scanner by one accepted byte and queue the packet result on the
  // final byte.
  function automatic void scan_byte(input byte_t d, input logic last, input logic vid);
    res_t pkt_res;
    logic key;
    if (vid) begin
      // The candidate at the oldest window byte is tested once four bytes follow it.
      if (fill >= WIN_FULL && !got_idr) begin
        if (skip_left != '0) begin
          skip_left = skip_left - 3'd1;
        end else if (win[0] == SC_ZERO && win[1] == SC_ZERO) begin
          if (win[2] == SC_ONE) begin
            note_nal(win[3]);
            skip_left = SKIP_SHORT;
          end else if (win[2] == SC_ZERO && win[3] == SC_ONE) begin
            note_nal(d);
            skip_left = SKIP_LONG;
          end
        end
      end
      win[0] = win[1];
      win[1] = win[2];
      win[2] = win[3];
      win[3] = d;
      if (fill < WIN_FULL) fill = fill + 3'd1;
    end
    if (!last) return;

    pkt_res = '0;
    if (vid) begin
      key = got_sps && got_pps && got_idr;
      if (key) first_key = 1'b1;
      // Video before the first keyframe is dropped with every field zero.
      if (first_key) begin
        pkt_res.accepted  = 1'b1;
        pkt_res.key_frame = key;
        pkt_res.timestamp = video_time;
        pkt_res.duration  = video_dur;
        video_time        = video_time + {{(TimeW-DurW){1'b0}}, video_dur};
      end
    end else begin
      pkt_res.accepted  = 1'b1;
      pkt_res.stream_id = 1'b1;
      pkt_res.timestamp = audio_time;
      pkt_res.duration  = audio_dur;
      audio_time        = audio_time + {{(TimeW-DurW){1'b0}}, audio_dur};
    end
    packet_results_q.push_back(pkt_res);
    start_new_packet();
  endfunction

  // One line per mismatch, and the count.
  task automatic report(input string what, input logic [TimeW-1:0] got,
                        input logic [TimeW-1:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Compare a result transfer with the oldest expectation, field by field.
  task automatic check_result();
    res_t got;
    res_t want;
    got.accepted  = res.accepted;
    got.key_frame = res.key_frame;
    got.stream_id = res.stream_id;
    got.timestamp = res.timestamp;
    got.duration  = res.duration;
    if (packet_results_q.size() == 0) begin
      report("result with no packet ended", got.timestamp, '0);
      return;
    end
    want = packet_results_q.pop_front();
    results_checked++;
    if (got.accepted !== want.accepted)
      report("accepted", TimeW'(got.accepted), TimeW'(want.accepted));
    if (got.key_frame !== want.key_frame)
      report("key_frame", TimeW'(got.key_frame), TimeW'(want.key_frame));
    if (got.stream_id !== want.stream_id)
      report("stream_id", TimeW'(got.stream_id), TimeW'(want.stream_id));
    if (got.timestamp !== want.timestamp)
      report("timestamp", got.timestamp, want.timestamp);
    if (got.duration !== want.duration)
      report("duration", TimeW'(got.duration), TimeW'(want.duration));
  endtask

  // Watch all three channels at each rising edge. A byte taken in the same cycle
  // as a register write still sees the old durations.
  always @(posedge clk) begin
    if (rst) begin
      video_dur       = VIDEO_DUR_RESET;
      audio_dur       = AUDIO_DUR_RESET;
      first_key       = 1'b0;
      video_time      = '0;
      audio_time      = '0;
      mismatches      = 0;
      results_checked = 0;
      packet_results_q.delete();
      start_new_packet();
    end else begin
      if (res.valid && res.ready) check_result();
      if (pkt.valid && pkt.ready) scan_byte(pkt.data_byte, pkt.last_byte, pkt.is_video);
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_VIDEO_DUR: video_dur = cfg.data;
          CFG_AUDIO_DUR: audio_dur = cfg.data;
          default: ;
        endcase
      end
    end
    outstanding = packet_results_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import h264kg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     LIMIT_CYCLES = 200000;
  localparam int unsigned     NUM_PHASES   = 4;
  localparam int unsigned     PHASE_BYTES  = 457;
  localparam int unsigned     HOLD_CYCLES  = 300;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [NalW-1:0] NAL_SEI      = 5'd6;
  localparam byte_t           IDR_HEAD     = {3'b011, NAL_IDR};

  typedef struct packed {
    byte_t data;
    logic  video;
  } beat_t;

  logic clk;
  logic rst;

  h264kg_pkt_if pkt_if ();
  h264kg_res_if res_if ();
  h264kg_cfg_if cfg_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int          hold_len;
  int unsigned bytes_sent;
  int unsigned packets_sent;
  beat_t       frame_q [$];

  h264_keyframe_gate_timestamper_top u_top (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  h264kg_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .pkt             (pkt_if),
    .res             (res_if),
    .cfg             (cfg_if),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        res_if.ready <= 1'b0;
        hold_len--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Run limit.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run limit of %0d cycles reached with %0d results owed", LIMIT_CYCLES,
             outstanding);
    $display("** h264_keyframe_gate_timestamper_top: FAILED **");
    $finish;
  end

  // Random single bit.
  function automatic logic coin();
    return ($urandom_range(1) != 0);
  endfunction

  // Payload byte with a bias towards the start code values.
  function automatic byte_t body_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return SC_ZERO;
    if (r == 1) return SC_ONE;
    return byte_t'($urandom);
  endfunction

  task automatic put(input byte_t d, input logic vid);
    beat_t b;
    b.data  = d;
    b.video = vid;
    frame_q.push_back(b);
  endtask

  // Video NAL unit: three- or four-byte start code, header, then payload.
  task automatic put_nal(input logic [NalW-1:0] nal, input logic lng,
                         input int unsigned body_len);
    byte_t hdr;
    hdr = byte_t'($urandom);
    hdr[NalW-1:0] = nal;
    if (lng) put(SC_ZERO, 1'b1);
    put(SC_ZERO, 1'b1);
    put(SC_ZERO, 1'b1);
    put(SC_ONE, 1'b1);
    put(hdr, 1'b1);
    repeat (body_len) put(body_byte(), 1'b1);
  endtask

  // Offer one byte, idling first at random, and wait for its transfer.
  task automatic send_byte(input byte_t d, input logic last, input logic vid);
    while ($urandom_range(99) < src_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_if.valid     <= 1'b1;
    pkt_if.data_byte <= d;
    pkt_if.last_byte <= last;
    pkt_if.is_video  <= vid;
    do @(posedge clk); while (!pkt_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_byte(frame_q[i].data, i == frame_q.size() - 1, frame_q[i].video);
    frame_q.delete();
    packets_sent++;
  endtask

  // Stop offering and wait until every packet result has come back.
  task automatic wait_drain();
    pkt_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Offer one register write and wait for its transfer; the caller lowers valid.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_durations(input logic [DurW-1:0] vid_dur,
                                   input logic [DurW-1:0] aud_dur,
                                   input logic [CfgIdxW-1:0] spare);
    write_reg(CFG_VIDEO_DUR, vid_dur);
    write_reg(CFG_AUDIO_DUR, aud_dur);
    write_reg(spare, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  // One random packet, mostly well-formed video around the keyframe rule.
  task automatic random_frame();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Keyframe: optional junk and SEI in front, parameter sets in either order,
      // and sometimes a further SPS after the IDR that the scan must not see.
      if ($urandom_range(1)) repeat ($urandom_range(3)) put(body_byte(), 1'b1);
      if ($urandom_range(3) == 0) put_nal(NAL_SEI, coin(), $urandom_range(4));
      if ($urandom_range(1)) begin
        put_nal(NAL_SPS, coin(), $urandom_range(6));
        put_nal(NAL_PPS, coin(), $urandom_range(6));
      end else begin
        put_nal(NAL_PPS, coin(), $urandom_range(6));
        put_nal(NAL_SPS, coin(), $urandom_range(6));
      end
      put_nal(NAL_IDR, coin(), 1 + $urandom_range(5));
      if ($urandom_range(1)) put_nal(NAL_SPS, coin(), $urandom_range(3));
    end else if (pick < 50) begin
      // Ordinary slices, with any NAL type.
      n = 1 + $urandom_range(2);
      repeat (n) put_nal(NalW'($urandom_range(31)), coin(), 1 + $urandom_range(6));
    end else if (pick < 60) begin
      // Broken keyframes: a parameter set missing, or the IDR ahead of both.
      case ($urandom_range(2))
        0: begin
          put_nal(NAL_SPS, coin(), $urandom_range(4));
          put_nal(NAL_IDR, coin(), 1 + $urandom_range(4));
        end
        1: begin
          put_nal(NAL_PPS, coin(), $urandom_range(4));
          put_nal(NAL_IDR, coin(), 1 + $urandom_range(4));
        end
        default: begin
          put_nal(NAL_IDR, coin(), $urandom_range(4));
          put_nal(NAL_SPS, coin(), $urandom_range(4));
          put_nal(NAL_PPS, coin(), 1 + $urandom_range(4));
        end
      endcase
    end else if (pick < 80) begin
      // Audio packet.
      repeat (1 + $urandom_range(9)) put(byte_t'($urandom), 1'b0);
    end else if (pick < 88) begin
      // Video too short to test any candidate, often a truncated start code.
      n = 1 + $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1))
          put(i < 2 ? SC_ZERO : (i == 2 ? SC_ONE : IDR_HEAD), 1'b1);
        else
          put(body_byte(), 1'b1);
      end
    end else begin
      // Noise with the kind changing from byte to byte.
      repeat (1 + $urandom_range(15)) put(body_byte(), coin());
    end
    send_frame();
  endtask

  // Stimulus.
  initial begin
    int unsigned phase_end;
    int unsigned keep_idle;
    bit          mid_done;
    rst              = 1'b1;
    pkt_if.valid     = 1'b0;
    pkt_if.data_byte = '0;
    pkt_if.last_byte = 1'b0;
    pkt_if.is_video  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    src_idle_pct     = 27;
    snk_idle_pct     = 71;
    hold_len         = 0;
    bytes_sent       = 0;
    packets_sent     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // A write to an unused index must leave the reset durations alone.
    write_reg(CFG_SPARE_A, $urandom);
    cfg_if.valid <= 1'b0;

    // Four-byte video packet: no candidate can be tested, so it is dropped.
    put(SC_ZERO, 1'b1);
    put(SC_ZERO, 1'b1);
    put(SC_ONE, 1'b1);
    put(IDR_HEAD, 1'b1);
    send_frame();
    // Single audio byte at the top of the byte range.
    put(8'hff, 1'b0);
    send_frame();
    // Smallest keyframe behind three-byte start codes.
    put_nal(NAL_SPS, 1'b0, 0);
    put_nal(NAL_PPS, 1'b0, 0);
    put_nal(NAL_IDR, 1'b0, 1);
    send_frame();
    // IDR alone behind a four-byte start code: passed on, but not a keyframe.
    put_nal(NAL_IDR, 1'b1, 0);
    send_frame();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Durations change only once the block has gone idle.
      if (ph != 0) wait_drain();
      case (ph)
        0: ;
        1: program_durations(32'hffff_ffff, 32'h0, CFG_SPARE_B);
        2: program_durations(32'h0, 32'hffff_ffff, CFG_SPARE_A);
        default: program_durations($urandom, $urandom, CFG_SPARE_B);
      endcase
      case (ph)
        0: begin src_idle_pct = 27; snk_idle_pct = 71; end
        1: begin src_idle_pct = 71; snk_idle_pct = 27; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase

      phase_end = 23 + (ph + 1) * PHASE_BYTES;
      mid_done  = 1'b0;
      while (bytes_sent < phase_end) begin
        if (!mid_done && bytes_sent + PHASE_BYTES / 2 >= phase_end) begin
          mid_done = 1'b1;
          if (ph == 1) begin
            // Long receiver hold-off while packets keep coming, to fill the block.
            keep_idle    = src_idle_pct;
            src_idle_pct = 0;
            hold_len     = HOLD_CYCLES;
            repeat (12) random_frame();
            src_idle_pct = keep_idle;
          end else if (ph == 2) begin
            wait_drain();
          end
        end
        random_frame();
      end
    end
    wait_drain();

    $display("Covered %0d bytes in %0d packets over four duration settings; %0d results checked.",
             bytes_sent, packets_sent, results_checked);
    $display("Idling ran sender-heavy, receiver-heavy and free, with a long hold-off and drain.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("** h264_keyframe_gate_timestamper_top: PASSED **");
    end else begin
      $display("** h264_keyframe_gate_timestamper_top: FAILED **");
    end
    $finish;
  end

endmodule
